>>> rtl/adll_pkg.sv
// Shared types, codes and default sizes for the array-backed doubly linked list.
// Used by every module in rtl/; depends on nothing.
package adll_pkg;

    localparam int OPC_W      = 4;
    localparam int NODE_W     = 4;
    localparam int RES_VAL_W  = 32;
    localparam int STAT_W     = 2;

    localparam int ENTRIES_DEF    = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_RESULTS    = 15;
    localparam int CNT_W          = $clog2(MAX_RESULTS);
    localparam int Q_DEPTH        = 2;

    typedef logic [OPC_W-1:0] t_kind;

    localparam t_kind OP_CLEAR      = 4'd0;
    localparam t_kind OP_PUSH_BACK  = 4'd1;
    localparam t_kind OP_PUSH_FRONT = 4'd2;
    localparam t_kind OP_INSERT     = 4'd3;
    localparam t_kind OP_POP_BACK   = 4'd4;
    localparam t_kind OP_POP_FRONT  = 4'd5;
    localparam t_kind OP_REMOVE     = 4'd6;
    localparam t_kind OP_WALK_FWD   = 4'd7;
    localparam t_kind OP_WALK_BACK  = 4'd8;
    localparam t_kind OP_NOP        = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        t_kind kind;
        logic  node_rng;
    } t_cmd_ctl;

    localparam int CMD_W_DEF = $bits(t_cmd_ctl) + VALUE_BITS_DEF + NODE_W;

endpackage

>>> rtl/adll_front.sv
// Front end: takes command beats, decodes the opcode and range-checks the node.
// Depends on adll_pkg; feeds adll_queue.
module adll_front #(
    parameter int ENTRIES    = adll_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = adll_pkg::VALUE_BITS_DEF
) (
    input  logic                            start,
    output logic                            busy,
    input  logic [adll_pkg::OPC_W-1:0]      i_opcode,
    input  logic signed [adll_pkg::RES_VAL_W-1:0] i_value,
    input  logic [adll_pkg::NODE_W-1:0]     i_node,
    input  logic                            i_q_full,
    output logic                            o_push,
    output adll_pkg::t_cmd_ctl              o_ctl,
    output logic signed [VALUE_BITS-1:0]    o_value,
    output logic [adll_pkg::NODE_W-1:0]     o_node
);
    import adll_pkg::*;

    assign busy   = i_q_full;
    assign o_push = start && !i_q_full;

    // Opcodes past the last walk all collapse onto one do-nothing code.
    assign o_ctl.kind     = (i_opcode > OP_WALK_BACK) ? OP_NOP : i_opcode;
    assign o_ctl.node_rng = (i_node != '0) && (32'(i_node) < 32'(ENTRIES));

    assign o_value = VALUE_BITS'(i_value);
    assign o_node  = i_node;

endmodule

>>> rtl/adll_queue.sv
// Short command queue between the front and back ends.
// Depends on adll_pkg for its default sizes.
module adll_queue #(
    parameter int WIDTH = adll_pkg::CMD_W_DEF,
    parameter int DEPTH = adll_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [LVL_W-1:0] r_lvl, n_lvl;

    assign o_full  = (r_lvl == LVL_W'(DEPTH));
    assign o_empty = (r_lvl == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_lvl = r_lvl;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_lvl = r_lvl + 1'b1;
        end else if (i_pop && !i_push) begin
            n_lvl = r_lvl - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/adll_back.sv
// Back end: link and value memories, head/tail/free pointers and the sequencer
// that carries out each command. Depends on adll_pkg; fed by adll_queue.
module adll_back #(
    parameter int ENTRIES    = adll_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = adll_pkg::VALUE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cmd_valid,
    output logic                                  o_cmd_pop,
    input  adll_pkg::t_cmd_ctl                    i_ctl,
    input  logic signed [VALUE_BITS-1:0]          i_value,
    input  logic [adll_pkg::NODE_W-1:0]           i_node,
    output logic                                  o_res_valid,
    output logic signed [adll_pkg::RES_VAL_W-1:0] o_value_res,
    output logic [adll_pkg::NODE_W-1:0]           o_node_index,
    output logic [adll_pkg::STAT_W-1:0]           o_status,
    output logic                                  o_last
);
    import adll_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_B    = 2'd1;
    localparam logic [1:0] S_C    = 2'd2;
    localparam logic [1:0] S_WALK = 2'd3;

    // Successor link as it stands after reset: the free chain.
    function automatic logic [IDX_W-1:0] link_rst(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0 || a == IDX_W'(ENTRIES - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    logic [1:0]                    r_state, n_state;
    t_kind                         r_kind, n_kind;
    logic signed [VALUE_BITS-1:0]  r_val, n_val;
    logic [IDX_W-1:0]              r_node, n_node, r_n, n_n;
    logic [IDX_W-1:0]              r_head, n_head, r_tail, n_tail, r_free, n_free;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [ENTRIES-1:0]            r_in_use, n_in_use, r_nvld, n_nvld, r_pvld, n_pvld;

    logic [IDX_W-1:0]              r_next_mem [ENTRIES];
    logic [IDX_W-1:0]              r_prev_mem [ENTRIES];
    logic signed [VALUE_BITS-1:0]  r_val_mem  [ENTRIES];

    logic [IDX_W-1:0]              r_qn0, r_qn1, r_qp, r_ra0;
    logic signed [VALUE_BITS-1:0]  r_qv;
    logic                          r_nv0, r_nv1, r_pv;
    logic [IDX_W-1:0]              r_ra1;

    logic [IDX_W-1:0]              rd_a0, rd_a1;
    logic                          we_n, we_p, we_v;
    logic [IDX_W-1:0]              wa_n, wd_n, wa_p, wd_p, wa_v;
    logic signed [VALUE_BITS-1:0]  wd_v;

    logic [IDX_W-1:0]              eff_n0, eff_n1, eff_p, nx, q_idx, w_first, p_tgt;
    logic                          fin, node_ok, clr;

    logic                          r_ovld, n_ovld, r_olast, n_olast;
    logic signed [RES_VAL_W-1:0]   r_oval, n_oval;
    logic [NODE_W-1:0]             r_onode, n_onode;
    logic [STAT_W-1:0]             r_ost, n_ost;

    // Entries never written since reset or clear read as their reset value.
    assign eff_n0 = r_nv0 ? r_qn0 : link_rst(r_ra0);
    assign eff_n1 = r_nv1 ? r_qn1 : link_rst(r_ra1);
    assign eff_p  = r_pv  ? r_qp  : '0;

    assign nx      = (r_kind == OP_WALK_FWD) ? eff_n0 : eff_p;
    assign fin     = (nx == '0) || (r_cnt == CNT_W'(MAX_RESULTS - 1));
    assign q_idx   = IDX_W'(i_node);
    assign node_ok = i_ctl.node_rng && r_in_use[q_idx];
    assign w_first = (i_ctl.kind == OP_WALK_FWD) ? r_head : r_tail;
    assign p_tgt   = (i_ctl.kind == OP_POP_BACK)  ? r_tail :
                     (i_ctl.kind == OP_POP_FRONT) ? r_head : q_idx;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_val    = r_val;
        n_node   = r_node;
        n_n      = r_n;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_in_use = r_in_use;
        n_ovld   = 1'b0;
        n_oval   = r_oval;
        n_onode  = r_onode;
        n_ost    = r_ost;
        n_olast  = r_olast;
        o_cmd_pop = 1'b0;
        clr      = 1'b0;
        rd_a0    = r_n;
        rd_a1    = q_idx;
        we_n     = 1'b0;
        wa_n     = r_n;
        wd_n     = '0;
        we_p     = 1'b0;
        wa_p     = r_n;
        wd_p     = '0;
        we_v     = 1'b0;
        wa_v     = r_free;
        wd_v     = i_value;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_kind  = i_ctl.kind;
                    n_val   = i_value;
                    n_node  = q_idx;
                    n_olast = 1'b1;
                    n_oval  = '0;
                    n_onode = '0;
                    n_ost   = ST_OK;
                    case (i_ctl.kind)
                        OP_CLEAR: begin
                            clr    = 1'b1;
                            n_ovld = 1'b1;
                        end
                        OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                            // The node check comes before the pool-full check.
                            if (i_ctl.kind == OP_INSERT && !node_ok) begin
                                n_ovld = 1'b1;
                                n_ost  = ST_INVALID;
                            end else if (r_free == '0) begin
                                n_ovld = 1'b1;
                                n_ost  = ST_FULL;
                            end else begin
                                n_n   = r_free;
                                rd_a0 = r_free;
                                we_v  = 1'b1;
                                we_p  = 1'b1;
                                wa_p  = r_free;
                                if (i_ctl.kind == OP_PUSH_BACK) begin
                                    wd_p = r_tail;
                                end else if (i_ctl.kind == OP_INSERT) begin
                                    wd_p = q_idx;
                                end
                                n_state = S_B;
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
                            if (i_ctl.kind == OP_REMOVE && !node_ok) begin
                                n_ovld = 1'b1;
                                n_ost  = ST_INVALID;
                            end else if (i_ctl.kind != OP_REMOVE && r_head == '0) begin
                                n_ovld = 1'b1;
                                n_ost  = ST_EMPTY;
                            end else begin
                                n_n     = p_tgt;
                                rd_a0   = p_tgt;
                                n_state = S_B;
                            end
                        end
                        OP_WALK_FWD, OP_WALK_BACK: begin
                            if (w_first == '0) begin
                                n_ovld = 1'b1;
                                n_ost  = ST_EMPTY;
                            end else begin
                                n_n     = w_first;
                                rd_a0   = w_first;
                                n_cnt   = '0;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_ovld = 1'b1;
                        end
                    endcase
                end
            end
            S_B: begin
                case (r_kind)
                    OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                        n_free       = eff_n0;
                        n_in_use[r_n] = 1'b1;
                        we_n         = 1'b1;
                        wa_n         = r_n;
                        if (r_kind == OP_PUSH_BACK) begin
                            wd_n    = '0;
                            n_state = S_C;
                        end else if (r_kind == OP_PUSH_FRONT) begin
                            wd_n = r_head;
                            if (r_head != '0) begin
                                we_p = 1'b1;
                                wa_p = r_head;
                                wd_p = r_n;
                            end else begin
                                n_tail = r_n;
                            end
                            n_head  = r_n;
                            n_ovld  = 1'b1;
                            n_olast = 1'b1;
                            n_ost   = ST_OK;
                            n_oval  = '0;
                            n_onode = NODE_W'(r_n);
                            n_state = S_IDLE;
                        end else begin
                            wd_n = eff_n1;
                            if (eff_n1 != '0) begin
                                we_p = 1'b1;
                                wa_p = eff_n1;
                                wd_p = r_n;
                            end else begin
                                n_tail = r_n;
                            end
                            n_state = S_C;
                        end
                    end
                    default: begin
                        // Pops and remove: splice the neighbours round the node.
                        n_val         = r_qv;
                        n_in_use[r_n] = 1'b0;
                        if (eff_p != '0) begin
                            we_n = 1'b1;
                            wa_n = eff_p;
                            wd_n = eff_n0;
                        end else begin
                            n_head = eff_n0;
                        end
                        if (eff_n0 != '0) begin
                            we_p = 1'b1;
                            wa_p = eff_n0;
                            wd_p = eff_p;
                        end else begin
                            n_tail = eff_p;
                        end
                        n_state = S_C;
                    end
                endcase
            end
            S_C: begin
                n_ovld  = 1'b1;
                n_olast = 1'b1;
                n_ost   = ST_OK;
                n_onode = NODE_W'(r_n);
                n_oval  = '0;
                n_state = S_IDLE;
                we_n    = 1'b1;
                case (r_kind)
                    OP_PUSH_BACK: begin
                        if (r_tail != '0) begin
                            wa_n = r_tail;
                            wd_n = r_n;
                        end else begin
                            we_n   = 1'b0;
                            n_head = r_n;
                        end
                        n_tail = r_n;
                    end
                    OP_INSERT: begin
                        wa_n = r_node;
                        wd_n = r_n;
                    end
                    default: begin
                        // The freed node goes back on the front of the free chain.
                        wa_n   = r_n;
                        wd_n   = r_free;
                        we_p   = 1'b1;
                        wa_p   = r_n;
                        wd_p   = '0;
                        n_free = r_n;
                        n_oval = RES_VAL_W'(r_val);
                    end
                endcase
            end
            S_WALK: begin
                n_ovld  = 1'b1;
                n_oval  = RES_VAL_W'(r_qv);
                n_onode = NODE_W'(r_n);
                n_ost   = ST_OK;
                n_olast = fin;
                if (fin) begin
                    n_state = S_IDLE;
                end else begin
                    n_n   = nx;
                    rd_a0 = nx;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (clr) begin
            n_head   = '0;
            n_tail   = '0;
            n_free   = IDX_W'(1);
            n_in_use = '0;
        end
    end

    always_comb begin
        n_nvld = r_nvld;
        n_pvld = r_pvld;
        if (we_n) begin
            n_nvld[wa_n] = 1'b1;
        end
        if (we_p) begin
            n_pvld[wa_p] = 1'b1;
        end
        if (clr) begin
            n_nvld = '0;
            n_pvld = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_free   <= IDX_W'(1);
            r_in_use <= '0;
            r_nvld   <= '0;
            r_pvld   <= '0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_in_use <= n_in_use;
            r_nvld   <= n_nvld;
            r_pvld   <= n_pvld;
            r_ovld   <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_val   <= n_val;
        r_node  <= n_node;
        r_n     <= n_n;
        r_cnt   <= n_cnt;
        r_oval  <= n_oval;
        r_onode <= n_onode;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (we_n) begin
            r_next_mem[wa_n] <= wd_n;
        end
        if (we_p) begin
            r_prev_mem[wa_p] <= wd_p;
        end
        if (we_v) begin
            r_val_mem[wa_v] <= wd_v;
        end
        r_qn0 <= r_next_mem[rd_a0];
        r_qn1 <= r_next_mem[rd_a1];
        r_qp  <= r_prev_mem[rd_a0];
        r_qv  <= r_val_mem[rd_a0];
        r_ra0 <= rd_a0;
        r_ra1 <= rd_a1;
        r_nv0 <= r_nvld[rd_a0];
        r_nv1 <= r_nvld[rd_a1];
        r_pv  <= r_pvld[rd_a0];
    end

    assign o_res_valid  = r_ovld;
    assign o_value_res  = r_oval;
    assign o_node_index = r_onode;
    assign o_status     = r_ost;
    assign o_last       = r_olast;

`ifndef NO_ASSERTIONS
    a_head_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == '0) == (r_tail == '0))
        else $error("head and tail disagree on whether the list is empty");

    a_free_not_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != '0) |-> !r_in_use[r_free])
        else $error("free chain starts at a node that is in the list");

    a_walk_continuous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_last) |=> o_res_valid)
        else $error("walk results broke off before the last beat");

    a_fault_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != ST_OK) |->
        (o_last && o_node_index == '0 && o_value_res == '0))
        else $error("fault result is not a single empty beat");
`endif

endmodule

>>> rtl/array_doubly_linked_list.sv
// Top level of the array-backed doubly linked list with free chain.
// Depends on adll_pkg, adll_front, adll_queue and adll_back.
//
//   Channel  | Handshake             | Beat fields
//   ---------+-----------------------+----------------------------------------------
//   command  | start / busy          | i_opcode, i_value, i_node
//   result   | o_res_valid (strobe)  | o_value_res, o_node_index, o_status, o_last
//
// A command is taken when start is high and busy is low; busy rises only while
// the two-entry command queue is full. The back end answers clear, faults and
// unused opcodes from its idle state, push front via S_B, and push back, insert,
// pops and remove via S_B then S_C (a memory read, then link writes); a walk
// gives one beat per visited node. Each result beat stands for one cycle after
// its step and cannot be held off. Reset is synchronous and takes effect at
// once: per-entry valid bits stand in for clearing the link memories.
module array_doubly_linked_list #(
    parameter int ENTRIES    = adll_pkg::ENTRIES_DEF,
    parameter int VALUE_BITS = adll_pkg::VALUE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [adll_pkg::OPC_W-1:0]            i_opcode,
    input  logic signed [adll_pkg::RES_VAL_W-1:0] i_value,
    input  logic [adll_pkg::NODE_W-1:0]           i_node,
    output logic                                  o_res_valid,
    output logic signed [adll_pkg::RES_VAL_W-1:0] o_value_res,
    output logic [adll_pkg::NODE_W-1:0]           o_node_index,
    output logic [adll_pkg::STAT_W-1:0]           o_status,
    output logic                                  o_last
);
    import adll_pkg::*;

    localparam int CTL_W = $bits(t_cmd_ctl);
    localparam int CMD_W = CTL_W + VALUE_BITS + NODE_W;

    logic                         q_full, q_empty, q_push, q_pop;
    logic [CMD_W-1:0]             q_wdata, q_rdata;
    t_cmd_ctl                     f_ctl, b_ctl;
    logic signed [VALUE_BITS-1:0] f_value, b_value;
    logic [NODE_W-1:0]            f_node, b_node;

    adll_front #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .start    (start),
        .busy     (busy),
        .i_opcode (i_opcode),
        .i_value  (i_value),
        .i_node   (i_node),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_ctl    (f_ctl),
        .o_value  (f_value),
        .o_node   (f_node)
    );

    assign q_wdata = {f_ctl, f_value, f_node};

    adll_queue #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_ctl   = q_rdata[CMD_W-1 -: CTL_W];
    assign b_value = q_rdata[NODE_W +: VALUE_BITS];
    assign b_node  = q_rdata[NODE_W-1:0];

    adll_back #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!q_empty),
        .o_cmd_pop    (q_pop),
        .i_ctl        (b_ctl),
        .i_value      (b_value),
        .i_node       (b_node),
        .o_res_valid  (o_res_valid),
        .o_value_res  (o_value_res),
        .o_node_index (o_node_index),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

>>> bench/tb.sv
// Self-checking bench for array_doubly_linked_list: directed corner cases, then random
// phases that grow, shrink and churn the list, with beats predicted in a scoreboard class.
// Depends on adll_pkg and the RTL top level only.
module tb;
    import adll_pkg::*;

    localparam int LIST_SIZE    = ENTRIES_DEF;
    localparam int OPC_MAX      = (1 << OPC_W) - 1;
    localparam int NODE_MAX     = (1 << NODE_W) - 1;
    localparam int RANDOM_ITEMS = 430;
    localparam int QUIET_LIMIT  = 500;
    localparam int SETTLE       = 20;

    typedef struct {
        logic signed [RES_VAL_W-1:0] value;
        logic [NODE_W-1:0]           node;
        logic [STAT_W-1:0]           status;
        logic                        last;
    } t_beat;

    typedef enum int {MOOD_GROW, MOOD_SHRINK, MOOD_MIXED} t_mood;

    // Tracks the node pool and free chain, and holds the result beats still to come.
    class list_tracker;
        logic signed [RES_VAL_W-1:0] node_val [LIST_SIZE];
        logic [NODE_W-1:0]           succ [LIST_SIZE];
        logic [NODE_W-1:0]           pred [LIST_SIZE];
        bit                          live [LIST_SIZE];
        logic [NODE_W-1:0]           head_n, tail_n, free_n;
        t_beat                       pending [$];
        int                          errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < LIST_SIZE; i++) begin
                succ[i] = (i == 0 || i == LIST_SIZE - 1) ? '0 : NODE_W'(i + 1);
                pred[i] = '0;
                live[i] = 1'b0;
            end
            head_n = '0;
            tail_n = '0;
            free_n = NODE_W'(1);
        endfunction

        function void add_beat(logic signed [RES_VAL_W-1:0] value, logic [NODE_W-1:0] node,
                               logic [STAT_W-1:0] status, logic last);
            t_beat b;
            b.value  = value;
            b.node   = node;
            b.status = status;
            b.last   = last;
            pending.push_back(b);
        endfunction

        function logic [NODE_W-1:0] some_live_node();
            logic [NODE_W-1:0] picks [$];
            for (int i = 1; i < LIST_SIZE; i++)
                if (live[i]) picks.push_back(NODE_W'(i));
            if (picks.size() == 0) return '0;
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction

        function void take_command(t_kind op, logic signed [RES_VAL_W-1:0] v,
                                   logic [NODE_W-1:0] nd);
            bit                nd_ok;
            logic [NODE_W-1:0] n, p, x;
            int                k;
            nd_ok = nd != 0 && int'(nd) < LIST_SIZE && live[nd];
            case (op)
                OP_CLEAR: begin
                    wipe();
                    add_beat('0, '0, ST_OK, 1'b1);
                end
                OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                    // The node check is made before the pool is looked at.
                    if (op == OP_INSERT && !nd_ok) begin
                        add_beat('0, '0, ST_INVALID, 1'b1);
                    end else if (free_n == 0) begin
                        add_beat('0, '0, ST_FULL, 1'b1);
                    end else begin
                        n = free_n;
                        free_n = succ[n];
                        node_val[n] = v;
                        live[n] = 1'b1;
                        if (op == OP_PUSH_BACK) begin
                            succ[n] = '0;
                            pred[n] = tail_n;
                            if (tail_n != 0) succ[tail_n] = n; else head_n = n;
                            tail_n = n;
                        end else if (op == OP_PUSH_FRONT) begin
                            pred[n] = '0;
                            succ[n] = head_n;
                            if (head_n != 0) pred[head_n] = n; else tail_n = n;
                            head_n = n;
                        end else begin
                            x = succ[nd];
                            succ[n] = x;
                            pred[n] = nd;
                            succ[nd] = n;
                            if (x != 0) pred[x] = n; else tail_n = n;
                        end
                        add_beat('0, n, ST_OK, 1'b1);
                    end
                end
                OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
                    if (op == OP_REMOVE && !nd_ok) begin
                        add_beat('0, '0, ST_INVALID, 1'b1);
                    end else if (op != OP_REMOVE && head_n == 0) begin
                        add_beat('0, '0, ST_EMPTY, 1'b1);
                    end else begin
                        n = (op == OP_REMOVE) ? nd : (op == OP_POP_BACK) ? tail_n : head_n;
                        add_beat(node_val[n], n, ST_OK, 1'b1);
                        p = pred[n];
                        x = succ[n];
                        if (p != 0) succ[p] = x; else head_n = x;
                        if (x != 0) pred[x] = p; else tail_n = p;
                        // The freed node goes back on the front of the free chain.
                        succ[n] = free_n;
                        pred[n] = '0;
                        live[n] = 1'b0;
                        free_n = n;
                    end
                end
                OP_WALK_FWD, OP_WALK_BACK: begin
                    n = (op == OP_WALK_FWD) ? head_n : tail_n;
                    if (n == 0) add_beat('0, '0, ST_EMPTY, 1'b1);
                    k = 0;
                    // A walk is cut short after its maximum number of beats.
                    while (n != 0 && k < MAX_RESULTS) begin
                        x = (op == OP_WALK_FWD) ? succ[n] : pred[n];
                        add_beat(node_val[n], n, ST_OK, x == 0 || k == MAX_RESULTS - 1);
                        k++;
                        n = x;
                    end
                end
                default: add_beat('0, '0, ST_OK, 1'b1);
            endcase
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic signed [RES_VAL_W-1:0] value, logic [NODE_W-1:0] node,
                        logic [STAT_W-1:0] status, logic last);
            t_beat want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat: value %0d node %0d status %0d last %0b",
                                 value, node, status, last));
                return;
            end
            want = pending.pop_front();
            if (value !== want.value || node !== want.node || status !== want.status ||
                last !== want.last)
                report($sformatf({"beat mismatch: value %0d node %0d status %0d last %0b,",
                                  " wanted %0d %0d %0d %0b"}, value, node, status, last,
                                 want.value, want.node, want.status, want.last));
        endtask
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [OPC_W-1:0]            i_opcode;
    logic signed [RES_VAL_W-1:0] i_value;
    logic [NODE_W-1:0]           i_node;
    logic                        o_res_valid;
    logic signed [RES_VAL_W-1:0] o_value_res;
    logic [NODE_W-1:0]           o_node_index;
    logic [STAT_W-1:0]           o_status;
    logic                        o_last;

    list_tracker sb;
    int          burst_left = 0;
    int          quiet_cycles = 0;

    // Opcode weights per mood, in the order push back .. walk back; the rest is noise.
    int unsigned mood_weight [3][8] = '{
        '{25, 20, 25,  4,  4,  4,  8,  7},
        '{ 8,  7,  8, 18, 18, 20, 10,  8},
        '{14, 12, 14, 12, 12, 13, 10, 10}
    };

    array_doubly_linked_list u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .i_node       (i_node),
        .o_res_valid  (o_res_valid),
        .o_value_res  (o_value_res),
        .o_node_index (o_node_index),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Result beats are checked before the command taken at the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid) sb.check_beat(o_value_res, o_node_index, o_status, o_last);
            if (start && !busy) sb.take_command(i_opcode, i_value, i_node);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the command is taken.
    task automatic send_item(input t_kind op, input logic signed [RES_VAL_W-1:0] v,
                             input logic [NODE_W-1:0] nd);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= v;
        i_node   <= nd;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.pending.size() != 0);
        burst_left = 0;
    endtask

    task automatic pick_item(input t_mood mood, output t_kind op,
                             output logic signed [RES_VAL_W-1:0] v,
                             output logic [NODE_W-1:0] nd);
        int unsigned r, acc;
        r   = $urandom_range(0, 99);
        acc = 0;
        op  = t_kind'($urandom_range(0, OPC_MAX));
        for (int i = 0; i < 8; i++) begin
            acc += mood_weight[int'(mood)][i];
            if (r < acc) begin
                op = t_kind'(OP_PUSH_BACK + i);
                break;
            end
        end
        v = $urandom;
        if ((op == OP_INSERT || op == OP_REMOVE) && $urandom_range(0, 99) < 85)
            nd = sb.some_live_node();
        else
            nd = NODE_W'($urandom_range(0, NODE_MAX));
    endtask

    initial begin
        t_kind                       op;
        logic signed [RES_VAL_W-1:0] v;
        logic [NODE_W-1:0]           nd;
        t_mood                       mood;
        int                          sent;
        bit                          paused;
        sb = new();
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_opcode = OP_CLEAR;
        i_value  = '0;
        i_node   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty list and bad node handling first, then edge values through every operation.
        send_item(OP_WALK_FWD, '0, '0);
        send_item(OP_WALK_BACK, '0, '0);
        send_item(OP_POP_BACK, '0, '0);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_REMOVE, '0, '0);
        send_item(OP_INSERT, 32'sd99, 4'd7);
        send_item(OP_PUSH_BACK, 32'sh7FFF_FFFF, '0);
        send_item(OP_PUSH_FRONT, 32'sh8000_0000, '0);
        send_item(OP_PUSH_BACK, -32'sd1, '0);
        send_item(OP_INSERT, 32'sh5A5A_A5A5, sb.head_n);
        send_item(OP_INSERT, '0, sb.tail_n);
        send_item(OP_WALK_FWD, '0, '0);
        send_item(OP_WALK_BACK, '0, '0);
        send_item(OP_REMOVE, '0, 4'd4);
        send_item(OP_REMOVE, '0, 4'd4);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_POP_BACK, '0, '0);
        send_item(OP_REMOVE, '1, NODE_W'(NODE_MAX));
        send_item(OP_NOP, '1, NODE_W'(NODE_MAX));
        send_item(t_kind'(OPC_MAX), '1, NODE_W'(NODE_MAX));
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_WALK_FWD, '0, '0);
        send_item(OP_PUSH_FRONT, 32'sd1, '0);
        send_item(OP_POP_BACK, '0, '0);

        // The first phase favours growing the list; each later phase picks a random mood.
        sent   = 0;
        paused = 1'b0;
        mood   = MOOD_GROW;
        while (sent < RANDOM_ITEMS) begin
            repeat ($urandom_range(20, 60)) begin
                if (sent < RANDOM_ITEMS) begin
                    pick_item(mood, op, v, nd);
                    send_item(op, v, nd);
                    sent++;
                end
            end
            if (!paused || $urandom_range(0, 1) == 1) begin
                drain_results();
                paused = 1'b1;
                if ($urandom_range(0, 3) == 0) send_item(OP_CLEAR, $urandom, NODE_W'($urandom));
            end
            mood = t_mood'($urandom_range(0, 2));
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
